[rtl/core/bbd_pkg.sv]
// ----------------------------------------------------------------------------
// bbd_pkg
// Shared types and constants of the bilinear Bayer demosaic core.
// ----------------------------------------------------------------------------
package bbd_pkg;

  localparam int DEF_MAX_WIDTH      = 4096;
  localparam int DEF_MAX_HEIGHT     = 4096;
  localparam int DEF_GAIN_FRAC_BITS = 12;

  localparam int PIX_W      = 16;
  localparam int SIZE_CFG_W = 13;
  localparam int PACK_W     = 64;
  localparam int SUM_W      = 18;
  localparam int CNT_W      = 3;
  localparam int QUEUE_DEPTH = 4;

  localparam logic [1:0] CFG_IMAGE_WIDTH   = 2'd0;
  localparam logic [1:0] CFG_IMAGE_HEIGHT  = 2'd1;
  localparam logic [1:0] CFG_BLACK_LEVELS  = 2'd2;
  localparam logic [1:0] CFG_CHANNEL_GAINS = 2'd3;

  localparam logic [PACK_W-1:0] GAINS_RESET = 64'h1000_1000_1000_1000;

  // CFA site, encoded as {row odd, column odd}
  typedef enum logic [1:0] {
    SITE_R  = 2'd0,
    SITE_GR = 2'd1,
    SITE_GB = 2'd2,
    SITE_B  = 2'd3
  } site_t;

  typedef struct packed {
    logic vt;
    logic vb;
    logic vl;
    logic vr;
    logic rodd;
    logic codd;
    logic fe;
  } pos_t;

  typedef struct packed {
    logic [PIX_W-1:0] ctr;
    logic [SUM_W-1:0] sum_a;
    logic [CNT_W-1:0] cnt_a;
    logic [SUM_W-1:0] sum_b;
    logic [CNT_W-1:0] cnt_b;
    site_t            site;
    logic             fe;
  } entry_t;

endpackage

[rtl/core/bayer_bilinear_demosaic_core.sv]
// ----------------------------------------------------------------------------
// bayer_bilinear_demosaic_core
// Bilinear RGGB demosaic with black level and white-balance correction.
// ----------------------------------------------------------------------------
// Throughput: one pixel per cycle while out_tready stays high.
// An RGB pixel passes stage-1, window, queue and output registers after the
//   transfer that completes its window, one line plus one pixel behind it.
// The line stores read and write one column per cycle, which sets the rate.
// Reset (rst_n low, synchronous): position, pipeline and queue clear, the
//   registers return to 4096x4096, zero black levels and unity gains.
module bayer_bilinear_demosaic_core #(
  parameter int MAX_WIDTH      = bbd_pkg::DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT     = bbd_pkg::DEF_MAX_HEIGHT,
  parameter int GAIN_FRAC_BITS = bbd_pkg::DEF_GAIN_FRAC_BITS
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic [1:0]                    cfg_index,
  input  logic [bbd_pkg::PACK_W-1:0]    cfg_wdata,
  input  logic                          in_tvalid,
  output logic                          in_tready,
  input  logic [bbd_pkg::PIX_W-1:0]     in_tdata,   // raw_pixel
  input  logic                          in_tuser,   // mode
  output logic                          out_tvalid,
  input  logic                          out_tready,
  output logic [3*bbd_pkg::PIX_W-1:0]   out_tdata,  // red, green, blue
  output logic                          out_tlast
);
  import bbd_pkg::*;

  logic   adv, push, pop, not_empty;
  entry_t push_data, pop_data;

  assign in_tready = adv;

  bbd_front #(
    .MAX_WIDTH      (MAX_WIDTH),
    .MAX_HEIGHT     (MAX_HEIGHT),
    .GAIN_FRAC_BITS (GAIN_FRAC_BITS)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .in_valid  (in_tvalid),
    .in_mode   (in_tuser),
    .in_pixel  (in_tdata),
    .adv       (adv),
    .push      (push),
    .push_data (push_data)
  );

  bbd_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .pop_data  (pop_data),
    .not_full  (adv),
    .not_empty (not_empty)
  );

  bbd_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .not_empty  (not_empty),
    .pop_data   (pop_data),
    .pop        (pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

endmodule

[rtl/core/bbd_front.sv]
// ----------------------------------------------------------------------------
// bbd_front
// Position tracking, black level and gain correction, two line stores and
// the 3x3 window; emits neighbor sums for each output pixel.
// ----------------------------------------------------------------------------
module bbd_front #(
  parameter int MAX_WIDTH      = bbd_pkg::DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT     = bbd_pkg::DEF_MAX_HEIGHT,
  parameter int GAIN_FRAC_BITS = bbd_pkg::DEF_GAIN_FRAC_BITS
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic [1:0]                    cfg_index,
  input  logic [bbd_pkg::PACK_W-1:0]    cfg_wdata,
  input  logic                          in_valid,
  input  logic                          in_mode,
  input  logic [bbd_pkg::PIX_W-1:0]     in_pixel,
  input  logic                          adv,
  output logic                          push,
  output bbd_pkg::entry_t               push_data
);
  import bbd_pkg::*;

  localparam int CW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int RW = $clog2(MAX_HEIGHT + 2);

  logic [SIZE_CFG_W-1:0] width_r, height_r;
  logic [PACK_W-1:0]     black_r, gains_r;
  logic [RW-1:0]         row_r;
  logic [CW-1:0]         col_r;

  logic [15:0] w16, h16, wc, hc;
  logic [15:0] c1, r1, rr, cc, nc, nr;
  logic        drop, emit, fe;
  logic [PIX_W-1:0] blk, gain, dif;
  pos_t        pos;

  logic             s1_valid_r, s1_emit_r;
  logic [CW-1:0]    s1_col_r;
  logic [PIX_W-1:0] s1_d_r, s1_gain_r;
  pos_t             s1_pos_r;
  logic [PIX_W-1:0] top_rd_r, mid_rd_r;
  logic [31:0]      prod, scaled;
  logic [PIX_W-1:0] pix;

  logic [PIX_W-1:0] top_mem [MAX_WIDTH];
  logic [PIX_W-1:0] mid_mem [MAX_WIDTH];

  logic             s2_valid_r;
  pos_t             s2_pos_r;
  logic [PIX_W-1:0] win_r [9];

  logic [SUM_W-1:0] cross_s, diag_s, hor_s, ver_s;
  logic [CNT_W-1:0] cross_n, diag_n, hor_n, ver_n;
  site_t            site;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= SIZE_CFG_W'(4096);
      height_r <= SIZE_CFG_W'(4096);
      black_r  <= '0;
      gains_r  <= GAINS_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_IMAGE_WIDTH:   width_r  <= cfg_wdata[SIZE_CFG_W-1:0];
        CFG_IMAGE_HEIGHT:  height_r <= cfg_wdata[SIZE_CFG_W-1:0];
        CFG_BLACK_LEVELS:  black_r  <= cfg_wdata;
        CFG_CHANNEL_GAINS: gains_r  <= cfg_wdata;
        default:           width_r  <= width_r;
      endcase
    end
  end

  always_comb begin
    wc  = 16'(width_r);
    hc  = 16'(height_r);
    w16 = (wc < 16'd2) ? 16'd2 : ((wc > 16'(MAX_WIDTH)) ? 16'(MAX_WIDTH) : wc);
    h16 = (hc < 16'd2) ? 16'd2 : ((hc > 16'(MAX_HEIGHT)) ? 16'(MAX_HEIGHT) : hc);

    c1 = 16'(col_r);
    r1 = 16'(row_r);
    if (c1 >= w16) begin
      c1 = '0;
      r1 = r1 + 16'd1;
    end
    if (r1 > h16 + 16'd1 || (r1 == h16 + 16'd1 && c1 != '0)) begin
      r1 = '0;
      c1 = '0;
    end
    drop = in_mode && (r1 < h16);

    emit = 1'b1;
    rr   = '0;
    cc   = '0;
    if (c1 >= 16'd1 && r1 >= 16'd1) begin
      rr = r1 - 16'd1;
      cc = c1 - 16'd1;
    end else if (c1 == '0 && r1 >= 16'd2) begin
      rr = r1 - 16'd2;
      cc = w16 - 16'd1;
    end else begin
      emit = 1'b0;
    end

    nc = c1 + 16'd1;
    nr = r1;
    if (nc >= w16) begin
      nc = '0;
      nr = r1 + 16'd1;
    end
    fe = emit && (rr == h16 - 16'd1) && (cc == w16 - 16'd1);
    if (fe) begin
      nc = '0;
      nr = '0;
    end

    pos.vt   = (rr != '0);
    pos.vb   = (rr + 16'd1 < h16);
    pos.vl   = (cc != '0);
    pos.vr   = (cc + 16'd1 < w16);
    pos.rodd = rr[0];
    pos.codd = cc[0];
    pos.fe   = fe;

    unique case (site_t'({r1[0], c1[0]}))
      SITE_R: begin
        blk = black_r[15:0];
        gain = gains_r[15:0];
      end
      SITE_GR: begin
        blk = black_r[31:16];
        gain = gains_r[31:16];
      end
      SITE_GB: begin
        blk = black_r[47:32];
        gain = gains_r[47:32];
      end
      default: begin
        blk = black_r[63:48];
        gain = gains_r[63:48];
      end
    endcase
    dif = (r1 < h16 && in_pixel > blk) ? (in_pixel - blk) : '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_r <= '0;
      col_r <= '0;
    end else if (adv && in_valid) begin
      row_r <= drop ? RW'(r1) : RW'(nr);
      col_r <= drop ? CW'(c1) : CW'(nc);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      s1_emit_r  <= 1'b0;
    end else if (adv) begin
      s1_valid_r <= in_valid && !drop;
      s1_emit_r  <= emit;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_col_r  <= CW'(c1);
      s1_d_r    <= dif;
      s1_gain_r <= gain;
      s1_pos_r  <= pos;
      top_rd_r  <= top_mem[CW'(c1)];
      mid_rd_r  <= mid_mem[CW'(c1)];
    end
  end

  always_comb begin
    prod   = 32'(s1_d_r) * 32'(s1_gain_r);
    scaled = prod >> GAIN_FRAC_BITS;
    pix    = (scaled > 32'd65535) ? 16'hFFFF : scaled[PIX_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (adv && s1_valid_r) begin
      top_mem[s1_col_r] <= mid_rd_r;
      mid_mem[s1_col_r] <= pix;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_valid_r <= 1'b0;
      for (int k = 0; k < 9; k++) begin
        win_r[k] <= '0;
      end
    end else if (adv) begin
      s2_valid_r <= s1_valid_r && s1_emit_r;
      if (s1_valid_r) begin
        for (int k = 0; k < 3; k++) begin
          win_r[k*3]   <= win_r[k*3+1];
          win_r[k*3+1] <= win_r[k*3+2];
        end
        win_r[2] <= top_rd_r;
        win_r[5] <= mid_rd_r;
        win_r[8] <= pix;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s2_pos_r <= s1_pos_r;
    end
  end

  always_comb begin
    cross_s = (s2_pos_r.vt ? SUM_W'(win_r[1]) : '0) + (s2_pos_r.vb ? SUM_W'(win_r[7]) : '0)
            + (s2_pos_r.vl ? SUM_W'(win_r[3]) : '0) + (s2_pos_r.vr ? SUM_W'(win_r[5]) : '0);
    cross_n = CNT_W'(s2_pos_r.vt) + CNT_W'(s2_pos_r.vb)
            + CNT_W'(s2_pos_r.vl) + CNT_W'(s2_pos_r.vr);
    diag_s = ((s2_pos_r.vt && s2_pos_r.vl) ? SUM_W'(win_r[0]) : '0)
           + ((s2_pos_r.vt && s2_pos_r.vr) ? SUM_W'(win_r[2]) : '0)
           + ((s2_pos_r.vb && s2_pos_r.vl) ? SUM_W'(win_r[6]) : '0)
           + ((s2_pos_r.vb && s2_pos_r.vr) ? SUM_W'(win_r[8]) : '0);
    diag_n = CNT_W'(s2_pos_r.vt && s2_pos_r.vl) + CNT_W'(s2_pos_r.vt && s2_pos_r.vr)
           + CNT_W'(s2_pos_r.vb && s2_pos_r.vl) + CNT_W'(s2_pos_r.vb && s2_pos_r.vr);
    hor_s = (s2_pos_r.vl ? SUM_W'(win_r[3]) : '0) + (s2_pos_r.vr ? SUM_W'(win_r[5]) : '0);
    hor_n = CNT_W'(s2_pos_r.vl) + CNT_W'(s2_pos_r.vr);
    ver_s = (s2_pos_r.vt ? SUM_W'(win_r[1]) : '0) + (s2_pos_r.vb ? SUM_W'(win_r[7]) : '0);
    ver_n = CNT_W'(s2_pos_r.vt) + CNT_W'(s2_pos_r.vb);

    site = site_t'({s2_pos_r.rodd, s2_pos_r.codd});
    push_data.ctr  = win_r[4];
    push_data.site = site;
    push_data.fe   = s2_pos_r.fe;
    unique case (site)
      SITE_GR: begin
        push_data.sum_a = hor_s;
        push_data.cnt_a = hor_n;
        push_data.sum_b = ver_s;
        push_data.cnt_b = ver_n;
      end
      SITE_GB: begin
        push_data.sum_a = ver_s;
        push_data.cnt_a = ver_n;
        push_data.sum_b = hor_s;
        push_data.cnt_b = hor_n;
      end
      default: begin
        push_data.sum_a = cross_s;
        push_data.cnt_a = cross_n;
        push_data.sum_b = diag_s;
        push_data.cnt_b = diag_n;
      end
    endcase
    push = adv && s2_valid_r;
  end

endmodule

[rtl/core/bbd_queue.sv]
// ----------------------------------------------------------------------------
// bbd_queue
// Short register queue between the front and back parts.
// ----------------------------------------------------------------------------
module bbd_queue #(
  parameter int DEPTH = bbd_pkg::QUEUE_DEPTH
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  input  bbd_pkg::entry_t push_data,
  input  logic            pop,
  output bbd_pkg::entry_t pop_data,
  output logic            not_full,
  output logic            not_empty
);
  import bbd_pkg::*;

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int NW = $clog2(DEPTH + 1);

  entry_t        mem_r [DEPTH];
  logic [PW-1:0] wptr_r, rptr_r;
  logic [NW-1:0] count_r;

  assign not_full  = (count_r < NW'(DEPTH));
  assign not_empty = (count_r != '0);
  assign pop_data  = mem_r[rptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r  <= '0;
      rptr_r  <= '0;
      count_r <= '0;
    end else begin
      if (push) begin
        wptr_r <= (wptr_r == PW'(DEPTH - 1)) ? '0 : wptr_r + PW'(1);
      end
      if (pop) begin
        rptr_r <= (rptr_r == PW'(DEPTH - 1)) ? '0 : rptr_r + PW'(1);
      end
      count_r <= count_r + NW'(push) - NW'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wptr_r] <= push_data;
    end
  end

endmodule

[rtl/core/bbd_back.sv]
// ----------------------------------------------------------------------------
// bbd_back
// Divides the neighbor sums by their counts and holds the RGB result.
// ----------------------------------------------------------------------------
module bbd_back (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    not_empty,
  input  bbd_pkg::entry_t         pop_data,
  output logic                    pop,
  output logic                    out_tvalid,
  input  logic                    out_tready,
  output logic [3*bbd_pkg::PIX_W-1:0] out_tdata,
  output logic                    out_tlast
);
  import bbd_pkg::*;

  localparam int          DIV3_SHIFT = 19;
  localparam logic [17:0] DIV3_MUL   = 18'd174763;

  logic             out_valid_r, out_last_r;
  logic [PIX_W-1:0] red_r, grn_r, blu_r;
  logic [PIX_W-1:0] qa, qb, red_nxt, grn_nxt, blu_nxt;

  function automatic logic [PIX_W-1:0] avg(input logic [SUM_W-1:0] s,
                                           input logic [CNT_W-1:0] n);
    logic [2*SUM_W-1:0] p;
    logic [PIX_W-1:0]   q;
    begin
      p = (2*SUM_W)'(s) * (2*SUM_W)'(DIV3_MUL);
      unique case (n)
        3'd1:    q = s[PIX_W-1:0];
        3'd2:    q = s[PIX_W:1];
        3'd3:    q = p[DIV3_SHIFT +: PIX_W];
        3'd4:    q = s[PIX_W+1:2];
        default: q = '0;
      endcase
      return q;
    end
  endfunction

  assign pop = not_empty && (!out_valid_r || out_tready);

  always_comb begin
    qa = avg(pop_data.sum_a, pop_data.cnt_a);
    qb = avg(pop_data.sum_b, pop_data.cnt_b);
    unique case (pop_data.site)
      SITE_R: begin
        red_nxt = pop_data.ctr;
        grn_nxt = qa;
        blu_nxt = qb;
      end
      SITE_B: begin
        red_nxt = qb;
        grn_nxt = qa;
        blu_nxt = pop_data.ctr;
      end
      default: begin
        red_nxt = qa;
        grn_nxt = pop_data.ctr;
        blu_nxt = qb;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (pop) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      red_r      <= red_nxt;
      grn_r      <= grn_nxt;
      blu_r      <= blu_nxt;
      out_last_r <= pop_data.fe;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {blu_r, grn_r, red_r};
  assign out_tlast  = out_last_r;

endmodule

[rtl/core/bbd_checker.sv]
// ----------------------------------------------------------------------------
// bbd_checker
// Port-level checks of the demosaic core, bound to the top level.
// ----------------------------------------------------------------------------
module bbd_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [47:0] out_tdata,
  input logic        out_tlast
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid)
    else $error("result dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> $stable(out_tdata) && $stable(out_tlast))
    else $error("result changed while stalled");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result present after reset");

  a_backpressure: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> out_tvalid)
    else $error("input stalled with no result pending");

endmodule

bind bayer_bilinear_demosaic_core bbd_checker u_bbd_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tlast  (out_tlast)
);

[tb/sv/tb_bayer_bilinear_demosaic_core.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_bayer_bilinear_demosaic_core
// Self-checking bench for the bilinear RGGB demosaic core. Raw frames of many
// sizes, with drain ticks and noise, are streamed in under random stalls on
// both sides; a behavioral model of correction, line window and averaging
// predicts every RGB pixel and frame end, checked in order at the output.
// ----------------------------------------------------------------------------
module tb_bayer_bilinear_demosaic_core;
  import bbd_pkg::*;

  localparam int MAXW = DEF_MAX_WIDTH;
  localparam int MAXH = DEF_MAX_HEIGHT;
  localparam int WD_LIMIT = 2000;

  typedef struct {
    bit          drain;
    logic [15:0] raw;
  } raw_item_t;

  typedef struct {
    logic [15:0] red;
    logic [15:0] green;
    logic [15:0] blue;
    logic        fe;
  } rgb_pixel_t;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 cfg_we = 1'b0;
  logic [1:0]           cfg_index = CFG_IMAGE_WIDTH;
  logic [PACK_W-1:0]    cfg_wdata = '0;
  logic                 in_tvalid = 1'b0;
  logic                 in_tready;
  logic [PIX_W-1:0]     in_tdata = '0;  // raw_pixel
  logic                 in_tuser = 1'b0; // mode
  logic                 out_tvalid;
  logic                 out_tready = 1'b0;
  logic [3*PIX_W-1:0]   out_tdata;      // red, green, blue
  logic                 out_tlast;

  bayer_bilinear_demosaic_core u_top (
    .clk(clk), .rst_n(rst_n),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tlast(out_tlast)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  raw_item_t  raw_q[$];
  rgb_pixel_t rgb_expect_q[$];
  int         err_count = 0;

  // ---------------- demosaic predictor ----------------
  logic [12:0]  m_width = 13'd4096;
  logic [12:0]  m_height = 13'd4096;
  logic [63:0]  m_black = '0;
  logic [63:0]  m_gain = GAINS_RESET;
  logic [15:0]  m_lines[0:2*MAXW-1];
  logic [15:0]  m_win[0:8];
  int unsigned  m_in_row = 0, m_in_col = 0;

  function automatic int unsigned clamp_dim(logic [12:0] v, int unsigned hi);
    if (v < 2) return 2;
    if (v > hi) return hi;
    return 32'(v);
  endfunction

  function automatic logic [15:0] wb_correct(logic [15:0] raw, logic [1:0] site);
    logic [15:0] blk;
    logic [15:0] g;
    logic [31:0] d;
    logic [31:0] p;
    blk = m_black[site*16 +: 16];
    g = m_gain[site*16 +: 16];
    d = (raw > blk) ? 32'(raw - blk) : 32'd0;
    p = (d * 32'(g)) >> DEF_GAIN_FRAC_BITS;
    return (p > 32'hFFFF) ? 16'hFFFF : p[15:0];
  endfunction

  function automatic logic [15:0] avg4(logic [15:0] a, bit va, logic [15:0] b, bit vb,
                                       logic [15:0] c, bit vc, logic [15:0] d, bit vd);
    int unsigned s;
    int unsigned n;
    s = 0;
    n = 0;
    if (va) begin s += 32'(a); n++; end
    if (vb) begin s += 32'(b); n++; end
    if (vc) begin s += 32'(c); n++; end
    if (vd) begin s += 32'(d); n++; end
    return 16'((n != 0) ? s / n : 0);
  endfunction

  function automatic void predict_pixel(bit drain, logic [15:0] raw);
    int unsigned w, h, r, c;
    logic [15:0] pix, top, mid, red, grn, blu;
    bit vt, vb, vl, vr, hit;
    rgb_pixel_t px;
    w = clamp_dim(m_width, MAXW);
    h = clamp_dim(m_height, MAXH);
    pix = '0;
    hit = 1'b1;
    if (m_in_col >= w) begin m_in_col = 0; m_in_row++; end
    if (m_in_row > h + 1 || (m_in_row == h + 1 && m_in_col != 0)) begin
      m_in_row = 0;
      m_in_col = 0;
    end
    if (drain && m_in_row < h) return;
    if (m_in_row < h) pix = wb_correct(raw, {m_in_row[0], m_in_col[0]});
    top = m_lines[m_in_col];
    mid = m_lines[MAXW + m_in_col];
    m_lines[m_in_col] = mid;
    m_lines[MAXW + m_in_col] = pix;
    for (int k = 0; k < 3; k++) begin
      m_win[k*3] = m_win[k*3+1];
      m_win[k*3+1] = m_win[k*3+2];
    end
    m_win[2] = top;
    m_win[5] = mid;
    m_win[8] = pix;
    r = 0;
    c = 0;
    if (m_in_col >= 1 && m_in_row >= 1) begin
      r = m_in_row - 1; c = m_in_col - 1;
    end else if (m_in_col == 0 && m_in_row >= 2) begin
      r = m_in_row - 2; c = w - 1;
    end else begin
      hit = 1'b0;
    end
    m_in_col++;
    if (m_in_col >= w) begin m_in_col = 0; m_in_row++; end
    if (!hit) return;
    vt = r > 0; vb = r + 1 < h; vl = c > 0; vr = c + 1 < w;
    if (!r[0] && !c[0]) begin
      red = m_win[4];
      grn = avg4(m_win[1], vt, m_win[7], vb, m_win[3], vl, m_win[5], vr);
      blu = avg4(m_win[0], vt && vl, m_win[2], vt && vr, m_win[6], vb && vl,
                 m_win[8], vb && vr);
    end else if (r[0] && c[0]) begin
      blu = m_win[4];
      grn = avg4(m_win[1], vt, m_win[7], vb, m_win[3], vl, m_win[5], vr);
      red = avg4(m_win[0], vt && vl, m_win[2], vt && vr, m_win[6], vb && vl,
                 m_win[8], vb && vr);
    end else if (!r[0]) begin
      grn = m_win[4];
      red = avg4(m_win[3], vl, m_win[5], vr, 16'd0, 1'b0, 16'd0, 1'b0);
      blu = avg4(m_win[1], vt, m_win[7], vb, 16'd0, 1'b0, 16'd0, 1'b0);
    end else begin
      grn = m_win[4];
      red = avg4(m_win[1], vt, m_win[7], vb, 16'd0, 1'b0, 16'd0, 1'b0);
      blu = avg4(m_win[3], vl, m_win[5], vr, 16'd0, 1'b0, 16'd0, 1'b0);
    end
    px.red = red;
    px.green = grn;
    px.blue = blu;
    px.fe = (r == h - 1) && (c == w - 1);
    if (px.fe) begin m_in_row = 0; m_in_col = 0; end
    rgb_expect_q.push_back(px);
  endfunction

  // ---------------- input driver ----------------
  logic in_fire = 1'b0;
  logic out_fire = 1'b0;
  int   tx_gap = 0;
  bit   tx_calm = 1'b0;
  int   rx_wait = 0;
  bit   rx_calm = 1'b0;
  int   rx_hold_req = 0;
  int   rx_hold_done = 0;
  int   rx_hold_left = 0;

  always @(negedge clk) begin
    logic nxt_valid;
    raw_item_t it;
    nxt_valid = in_tvalid;
    if (rst_n) begin
      if (in_fire) begin
        nxt_valid = 1'b0;
        if ($urandom_range(0, 39) == 0) tx_calm = !tx_calm;
        tx_gap = tx_calm ? 0 : $urandom_range(0, 15);
      end
      if (!nxt_valid) begin
        if (tx_gap > 0) begin
          tx_gap--;
        end else if (raw_q.size() > 0) begin
          it = raw_q.pop_front();
          in_tdata <= it.raw;
          in_tuser <= it.drain;
          nxt_valid = 1'b1;
        end
      end
    end
    in_tvalid <= nxt_valid;
  end

  // ---------------- result receiver ----------------
  always @(negedge clk) begin
    logic rdy;
    rdy = 1'b0;
    if (rst_n) begin
      if (out_fire) begin
        if ($urandom_range(0, 39) == 0) rx_calm = !rx_calm;
        rx_wait = rx_calm ? 0 : $urandom_range(0, 15);
      end
      if (rx_hold_left > 0) begin
        rx_hold_left--;
      end else if (rx_hold_done < rx_hold_req) begin
        rx_hold_done++;
        rx_hold_left = 300;
      end else if (rx_wait > 0) begin
        rx_wait--;
      end else begin
        rdy = 1'b1;
      end
    end
    out_tready <= rdy;
  end

  // ---------------- monitors ----------------
  task automatic report_mismatch(string what, logic [15:0] got, logic [15:0] want);
    err_count++;
    $display("MISMATCH %s: got %0h expected %0h at %0t", what, got, want, $realtime);
  endtask

  always @(posedge clk) begin
    rgb_pixel_t px;
    in_fire <= rst_n && in_tvalid && in_tready;
    out_fire <= rst_n && out_tvalid && out_tready;
    if (rst_n && in_tvalid && in_tready) predict_pixel(in_tuser, in_tdata);
    if (rst_n && out_tvalid && out_tready) begin
      if (rgb_expect_q.size() == 0) begin
        report_mismatch("unexpected transfer", out_tdata[15:0], 16'd0);
      end else begin
        px = rgb_expect_q.pop_front();
        if (out_tdata[15:0] !== px.red) report_mismatch("red", out_tdata[15:0], px.red);
        if (out_tdata[31:16] !== px.green)
          report_mismatch("green", out_tdata[31:16], px.green);
        if (out_tdata[47:32] !== px.blue)
          report_mismatch("blue", out_tdata[47:32], px.blue);
        if (out_tlast !== px.fe)
          report_mismatch("frame_end", 16'(out_tlast), 16'(px.fe));
      end
    end
  end

  // ---------------- watchdog ----------------
  int idle_cycles = 0;
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || !rst_n)
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WD_LIMIT) begin
      $display("Timeout: no transfer for %0d cycles", WD_LIMIT);
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // ---------------- stimulus ----------------
  int pix_count = 0;

  task automatic write_reg(logic [1:0] idx, logic [63:0] val);
    @(negedge clk);
    cfg_we = 1'b1;
    cfg_index = idx;
    cfg_wdata = val;
    case (idx)
      CFG_IMAGE_WIDTH:   m_width = val[12:0];
      CFG_IMAGE_HEIGHT:  m_height = val[12:0];
      CFG_BLACK_LEVELS:  m_black = val;
      CFG_CHANNEL_GAINS: m_gain = val;
      default: ;
    endcase
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  task automatic wait_idle();
    while (raw_q.size() > 0 || in_tvalid || rgb_expect_q.size() > 0) @(posedge clk);
    repeat (10) @(posedge clk);
  endtask

  function automatic logic [15:0] rand_pixel();
    case ($urandom_range(0, 7))
      0: return 16'h0000;
      1: return 16'hFFFF;
      2: return 16'($urandom_range(0, 255));
      default: return 16'($urandom_range(0, 65535));
    endcase
  endfunction

  function automatic void push_item(bit drain, logic [15:0] raw);
    raw_item_t it;
    it.drain = drain;
    it.raw = raw;
    raw_q.push_back(it);
  endfunction

  // queue positions from the predictor's current place through frame end
  task automatic queue_frame(bit noise, int pause_at);
    int unsigned w, h, r, c, first, last;
    w = clamp_dim(m_width, MAXW);
    h = clamp_dim(m_height, MAXH);
    r = m_in_row;
    c = m_in_col;
    if (c >= w) begin c = 0; r++; end
    if (r > h + 1 || (r == h + 1 && c != 0)) begin r = 0; c = 0; end
    first = r * w + c;
    last = (h + 1) * w;
    for (int unsigned p = first; p <= last; p++) begin
      if (p == pause_at) wait_idle();
      if (p < h * w) begin
        if (noise && $urandom_range(0, 9) == 0) push_item(1'b1, rand_pixel());
        push_item(1'b0, rand_pixel());
        pix_count++;
      end else begin
        push_item(!(noise && $urandom_range(0, 3) == 0), rand_pixel());
      end
    end
  endtask

  function automatic logic [63:0] rand_gains();
    logic [63:0] g;
    for (int k = 0; k < 4; k++)
      case ($urandom_range(0, 3))
        0: g[k*16 +: 16] = 16'($urandom_range(0, 65535));
        1: g[k*16 +: 16] = 16'hFFFF;
        default: g[k*16 +: 16] = 16'($urandom_range(16'h0800, 16'h2000));
      endcase
    return g;
  endfunction

  function automatic logic [63:0] rand_blacks();
    logic [63:0] b;
    for (int k = 0; k < 4; k++)
      b[k*16 +: 16] = ($urandom_range(0, 3) == 0) ? 16'($urandom_range(0, 65535))
                                                   : 16'($urandom_range(0, 300));
    return b;
  endfunction

  initial begin
    for (int i = 0; i < 2*MAXW; i++) m_lines[i] = '0;
    for (int i = 0; i < 9; i++) m_win[i] = '0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // smallest frame, sizes below range, unity gains
    write_reg(CFG_IMAGE_WIDTH, 64'd0);
    write_reg(CFG_IMAGE_HEIGHT, 64'd1);
    write_reg(CFG_BLACK_LEVELS, 64'd0);
    write_reg(CFG_CHANNEL_GAINS, GAINS_RESET);
    push_item(1'b0, 16'h0000);
    push_item(1'b1, 16'hFFFF);
    push_item(1'b0, 16'hFFFF);
    push_item(1'b0, 16'hFFFF);
    push_item(1'b0, 16'h0000);
    push_item(1'b1, 16'h0000);
    push_item(1'b0, 16'h1234);
    push_item(1'b1, 16'h0000);
    wait_idle();

    // saturating gains, full black levels, odd size
    write_reg(CFG_IMAGE_WIDTH, 64'd3);
    write_reg(CFG_IMAGE_HEIGHT, 64'd3);
    write_reg(CFG_BLACK_LEVELS, 64'hFFFF_0000_8000_0010);
    write_reg(CFG_CHANNEL_GAINS, 64'hFFFF_FFFF_0000_FFFF);
    queue_frame(1'b1, -1);
    wait_idle();

    // wide line, height below range
    write_reg(CFG_IMAGE_WIDTH, 64'd30);
    write_reg(CFG_IMAGE_HEIGHT, 64'd0);
    write_reg(CFG_BLACK_LEVELS, 64'hFFFF_FFFF_FFFF_FFFF);
    write_reg(CFG_CHANNEL_GAINS, 64'h0);
    write_reg(CFG_BLACK_LEVELS, rand_blacks());
    write_reg(CFG_CHANNEL_GAINS, rand_gains());
    queue_frame(1'b0, -1);
    wait_idle();

    // width shrinks mid-frame
    write_reg(CFG_IMAGE_WIDTH, 64'd8);
    write_reg(CFG_IMAGE_HEIGHT, 64'd4);
    for (int i = 0; i < 13; i++) push_item(1'b0, rand_pixel());
    wait_idle();
    write_reg(CFG_IMAGE_WIDTH, 64'd4);
    queue_frame(1'b1, -1);
    wait_idle();

    // long receiver hold while frames keep coming
    write_reg(CFG_IMAGE_WIDTH, 64'd10);
    write_reg(CFG_IMAGE_HEIGHT, 64'd6);
    rx_hold_req++;
    queue_frame(1'b0, -1);
    queue_frame(1'b1, -1);
    wait_idle();

    while (pix_count < 650) begin
      write_reg(CFG_IMAGE_WIDTH, ($urandom_range(0, 5) == 0) ? 64'($urandom_range(0, 13))
                                                             : 64'(2 * $urandom_range(1, 6)));
      write_reg(CFG_IMAGE_HEIGHT, ($urandom_range(0, 5) == 0) ? 64'($urandom_range(0, 9))
                                                              : 64'(2 * $urandom_range(1, 4)));
      write_reg(CFG_BLACK_LEVELS, rand_blacks());
      write_reg(CFG_CHANNEL_GAINS, rand_gains());
      for (int f = $urandom_range(1, 3); f > 0; f--)
        queue_frame($urandom_range(0, 1), ($urandom_range(0, 4) == 0) ? 5 : -1);
      wait_idle();
    end

    wait_idle();
    repeat (20) @(posedge clk);
    if (rgb_expect_q.size() > 0) report_mismatch("missing results", 16'd0, 16'd0);
    if (err_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

[files.f]
rtl/core/bbd_pkg.sv
rtl/core/bbd_front.sv
rtl/core/bbd_queue.sv
rtl/core/bbd_back.sv
rtl/core/bayer_bilinear_demosaic_core.sv
rtl/core/bbd_checker.sv
tb/sv/tb_bayer_bilinear_demosaic_core.sv
